>>> design/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int NUM_SYMBOLS_DEF  = 256;
  localparam int BYTE_W           = 8;
  localparam int PEND_W           = 7;
  localparam int PCNT_W           = 3;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_t;

  // Request from the lookup stage to the packer
  typedef struct packed {
    logic load;   // lookup stage hands its item over this cycle
    logic flush;  // item is a flush, otherwise an encode
  } pack_req_t;

  // Status from the packer back to the lookup stage
  typedef struct packed {
    logic can_load;  // emitter is empty or frees up at this edge
  } pack_stat_t;

endpackage

>>> design/hcbp_code_table.sv
// ----------------------------------------------------------------------------
// hcbp_code_table
// Code word and code length memory; one write port, one registered read port.
// ----------------------------------------------------------------------------
module hcbp_code_table #(
  parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(NUM_SYMBOLS)-1:0]         wr_addr,
  input  logic [31:0]                            wr_code,
  input  logic [5:0]                             wr_len,
  input  logic                                   rd_en,
  input  logic [$clog2(NUM_SYMBOLS)-1:0]         rd_addr,
  output logic [31:0]                            rd_code,
  output logic [$clog2(MAX_CODE_LEN+1)-1:0]      rd_len
);
  import hcbp_pkg::*;

  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

  logic [31:0]      code_mem [NUM_SYMBOLS];
  logic [LEN_W-1:0] len_mem  [NUM_SYMBOLS];
  logic [LEN_W-1:0] len_sat;

  // Saturate long lengths at the maximum code length
  always_comb begin
    if (32'(wr_len) > 32'(MAX_CODE_LEN)) begin
      len_sat = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_sat = LEN_W'(wr_len);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[wr_addr] <= wr_code;
      len_mem[wr_addr]  <= len_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_code <= code_mem[rd_addr];
      rd_len  <= len_mem[rd_addr];
    end
  end

endmodule

>>> design/hcbp_packer.sv
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator and byte emitter: merges a code word with the pending bits,
// splits off whole bytes and emits one per cycle while result_ready holds.
// ----------------------------------------------------------------------------
module hcbp_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hcbp_pkg::pack_req_t               req,
  output hcbp_pkg::pack_stat_t              stat,
  input  logic [31:0]                       code,
  input  logic [$clog2(MAX_CODE_LEN+1)-1:0] len,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [7:0]                        out_byte,
  output logic                              byte_valid,
  output logic [2:0]                        pad_bits,
  output logic                              last
);
  import hcbp_pkg::*;

  localparam int ACC_W = PEND_W + MAX_CODE_LEN;
  localparam int TOT_W = $clog2(ACC_W + 1);
  localparam int NB    = ACC_W / BYTE_W;
  localparam int BUF_W = NB * BYTE_W;
  localparam int CNT_W = $clog2(NB + 1);

  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;
  logic [BUF_W-1:0]  emit_buf;
  logic [CNT_W-1:0]  emit_cnt;
  logic              emit_last;
  logic              emit_bvalid;
  logic [2:0]        emit_pad;

  logic [ACC_W-1:0]  code_w;
  logic [ACC_W-1:0]  code_mask;
  logic [ACC_W-1:0]  merged;
  logic [ACC_W-1:0]  aligned;
  logic [TOT_W-1:0]  total;
  logic [2:0]        rem;
  logic [PEND_W-1:0] rem_mask;
  logic [2:0]        flush_pad;
  logic [BYTE_W-1:0] flush_byte;
  logic              out_take;

  assign out_take      = result_valid && result_ready;
  assign stat.can_load = (emit_cnt == '0) || ((emit_cnt == CNT_W'(1)) && result_ready);

  // Append the code word below the pending bits, then left-align the result
  always_comb begin
    code_w     = ACC_W'(code);
    code_mask  = (ACC_W'(1) << len) - ACC_W'(1);
    merged     = (ACC_W'(pend_bits) << len) | (code_w & code_mask);
    total      = TOT_W'(pend_cnt) + TOT_W'(len);
    aligned    = merged << (TOT_W'(ACC_W) - total);
    rem        = total[2:0];
    rem_mask   = PEND_W'((8'd1 << rem) - 8'd1);
    flush_pad  = 3'(4'd8 - 4'(pend_cnt));
    flush_byte = BYTE_W'({1'b0, pend_bits} << flush_pad);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
      emit_cnt  <= '0;
    end else if (req.load) begin
      if (req.flush) begin
        pend_bits <= '0;
        pend_cnt  <= '0;
        emit_cnt  <= CNT_W'(1);
      end else begin
        pend_bits <= PEND_W'(merged) & rem_mask;
        pend_cnt  <= rem;
        emit_cnt  <= CNT_W'(total >> 3);
      end
    end else if (out_take) begin
      emit_cnt <= emit_cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      if (req.flush) begin
        emit_last   <= 1'b1;
        if (pend_cnt != '0) begin
          emit_buf    <= BUF_W'(flush_byte) << (BUF_W - BYTE_W);
          emit_bvalid <= 1'b1;
          emit_pad    <= flush_pad;
        end else begin
          emit_buf    <= '0;
          emit_bvalid <= 1'b0;
          emit_pad    <= '0;
        end
      end else begin
        emit_buf    <= aligned[ACC_W-1 -: BUF_W];
        emit_last   <= 1'b0;
        emit_bvalid <= 1'b1;
        emit_pad    <= '0;
      end
    end else if (out_take) begin
      // advance to the next byte
      emit_buf <= emit_buf << BYTE_W;
    end
  end

  assign result_valid = (emit_cnt != '0);
  assign out_byte     = emit_buf[BUF_W-1 -: BYTE_W];
  assign byte_valid   = emit_bvalid;
  assign pad_bits     = emit_pad;
  assign last         = emit_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    emit_cnt <= CNT_W'(NB))
    else $error("emitter byte count beyond buffer");

  a_load_drained: assert property (@(posedge clk) disable iff (rst)
    req.load |-> (emit_cnt == '0) || (emit_cnt == CNT_W'(1) && result_ready))
    else $error("emitter overwritten with bytes outstanding");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    req.load && req.flush |=> pend_cnt == '0 && result_valid && last)
    else $error("flush did not clear pending bits");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_valid |-> last && pad_bits == '0)
    else $error("empty result outside flush");

endmodule

>>> design/huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Streaming Huffman encoder: code table load, code lookup and byte packing.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  item      item_valid / item_ready      mode, symbol, code_bits, code_len
//  result    result_valid / result_ready  out_byte, byte_valid, pad_bits, last
//
//  An item reaches its first result through a table read, then the pack.
//  One item enters per cycle while each encode yields at most one byte and
//  result_ready is high; an encode yielding more bytes holds the input as the
//  emitter hands out one byte per cycle, set by the single result register.
//  Reset clears the pending bits and all valid state; the code table is
//  undefined until loaded.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  symbol,
  input  logic [31:0] code_bits,
  input  logic [5:0]  code_len,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic [2:0]  pad_bits,
  output logic        last
);
  import hcbp_pkg::*;

  localparam int SYM_W = $clog2(NUM_SYMBOLS);
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

  logic             accept;
  logic             sym_ok;
  logic             is_load;
  logic             is_encode;
  logic             is_flush;
  logic             s1_valid;
  logic             s1_flush;
  logic [31:0]      rd_code;
  logic [LEN_W-1:0] rd_len;
  pack_req_t        req;
  pack_stat_t       stat;

  assign sym_ok     = {1'b0, symbol} < 9'(NUM_SYMBOLS);
  assign is_load    = (mode == MODE_LOAD);
  assign is_encode  = (mode == MODE_ENCODE) && sym_ok;
  assign is_flush   = (mode == MODE_FLUSH);
  assign item_ready = !s1_valid || stat.can_load;
  assign accept     = item_valid && item_ready;

  // Hold the lookup stage until the packer takes it; drop items without results
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid && (is_encode || is_flush);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush <= is_flush;
    end
  end

  hcbp_code_table #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_table (
    .clk     (clk),
    .wr_en   (accept && is_load && sym_ok),
    .wr_addr (symbol[SYM_W-1:0]),
    .wr_code (code_bits),
    .wr_len  (code_len),
    .rd_en   (accept && is_encode),
    .rd_addr (symbol[SYM_W-1:0]),
    .rd_code (rd_code),
    .rd_len  (rd_len)
  );

  assign req.load  = s1_valid && stat.can_load;
  assign req.flush = s1_flush;

  hcbp_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_packer (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .stat         (stat),
    .code         (rd_code),
    .len          (rd_len),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .pad_bits     (pad_bits),
    .last         (last)
  );

endmodule
